// File: hdl/trpg_pkg.sv
// Shared types, constants and the byte shift function of the tile row preshift generator.
`default_nettype none

package trpg_pkg;

   localparam int unsigned TILE_W   = 64;
   localparam int unsigned BYTES    = 8;
   localparam int unsigned SHIFT_W  = 4;
   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned DATA_W   = 32;

   localparam logic [SHIFT_W-1:0] LAST_SHIFT  = 4'd8;
   localparam logic [SHIFT_W-1:0] FIRST_SHIFT = 4'd0;

   typedef enum logic [1:0] {
      REG_TILES_PER_ROW = 2'd0,
      REG_ROW_COUNT     = 2'd1,
      REG_DEST_BASE     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0]         tiles_per_row;
      logic [7:0]         row_count;
      logic [INDEX_W-1:0] dest_base;
   } cfg_type;

   // what the sequencer tells the shifter about the word in flight
   typedef struct packed {
      logic               plain;
      logic               trail;
      logic [SHIFT_W-1:0] shift;
   } gen_ctl_type;

   // low byte of {hi, lo} >> s: (lo >> s) | (hi << (8 - s)) for s in 0..8
   function automatic logic [7:0] shift_byte(input logic [7:0] hi, input logic [7:0] lo,
                                             input logic [SHIFT_W-1:0] s);
      logic [15:0] pair;
      pair = {hi, lo} >> s;
      return pair[7:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/trpg_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module trpg_csr
   import trpg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_TILES_PER_ROW: cfg_in.tiles_per_row = csr_pwdata[7:0];
            REG_ROW_COUNT:     cfg_in.row_count     = csr_pwdata[7:0];
            REG_DEST_BASE:     cfg_in.dest_base     = csr_pwdata[INDEX_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TILES_PER_ROW: csr_prdata = {24'd0, cfg_ff.tiles_per_row};
         REG_ROW_COUNT:     csr_prdata = {24'd0, cfg_ff.row_count};
         REG_DEST_BASE:     csr_prdata = {16'd0, cfg_ff.dest_base};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tiles_per_row <= 8'd1;
         cfg_ff.row_count     <= 8'd1;
         cfg_ff.dest_base     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/trpg_seq.sv
// Tile position tracking and the nine-or-eighteen word sequence for the tile in flight.
`default_nettype none

module trpg_seq
   import trpg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  wire logic               req_valid,
   input  wire logic [TILE_W-1:0]  req_tile_bytes,
   output logic                    req_stall,
   input  wire logic               out_free,
   output logic                    emit,
   output gen_ctl_type             gen_ctl,
   output logic [TILE_W-1:0]       gen_tile,
   output logic [TILE_W-1:0]       gen_prev,
   output logic                    item_last,
   output logic                    job_last,
   output logic [INDEX_W-1:0]      dest_tile
);

   logic               busy_ff, busy_in;
   logic               plain_ff, plain_in;
   logic               trail_ff, trail_in;
   logic               lastcol_ff, lastcol_in;
   logic               done_ff, done_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [7:0]         column_ff, column_in;
   logic [7:0]         row_ff, row_in;
   logic [INDEX_W-1:0] count_ff, count_in;
   logic [TILE_W-1:0]  tile_ff, prev_ff;

   logic [7:0] col_limit, row_limit;
   logic       last_col, last_row, accept;

   // a size written as zero acts as one
   assign col_limit = (cfg.tiles_per_row == 8'd0) ? 8'd0 : cfg.tiles_per_row - 8'd1;
   assign row_limit = (cfg.row_count == 8'd0) ? 8'd0 : cfg.row_count - 8'd1;
   assign last_col  = column_ff >= col_limit;
   assign last_row  = row_ff >= row_limit;

   assign item_last = (shift_ff == LAST_SHIFT) && (trail_ff || !lastcol_ff);
   assign job_last  = item_last && done_ff;
   assign emit      = busy_ff && out_free;
   // take the next tile in the cycle the final word of this one leaves
   assign req_stall = busy_ff && !(emit && item_last);
   assign accept    = req_valid && !req_stall;

   assign gen_ctl   = '{plain: plain_ff, trail: trail_ff, shift: shift_ff};
   assign gen_tile  = tile_ff;
   assign gen_prev  = prev_ff;
   assign dest_tile = cfg.dest_base + count_ff;

   always_comb begin
      busy_in    = busy_ff;
      plain_in   = plain_ff;
      trail_in   = trail_ff;
      lastcol_in = lastcol_ff;
      done_in    = done_ff;
      shift_in   = shift_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      count_in   = count_ff;

      if (emit) begin
         count_in = job_last ? '0 : count_ff + 16'd1;
         if (item_last) begin
            busy_in = 1'b0;
         end else if (shift_ff == LAST_SHIFT) begin
            // merged group done, start the trailing group
            shift_in = FIRST_SHIFT;
            trail_in = 1'b1;
         end else begin
            shift_in = shift_ff + 4'd1;
         end
      end

      if (accept) begin
         busy_in    = 1'b1;
         plain_in   = (column_ff == 8'd0);
         trail_in   = 1'b0;
         lastcol_in = last_col;
         done_in    = last_col && last_row;
         shift_in   = FIRST_SHIFT;
         if (last_col) begin
            column_in = 8'd0;
            row_in    = last_row ? 8'd0 : row_ff + 8'd1;
         end else begin
            column_in = column_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         plain_ff   <= 1'b0;
         trail_ff   <= 1'b0;
         lastcol_ff <= 1'b0;
         done_ff    <= 1'b0;
         shift_ff   <= FIRST_SHIFT;
         column_ff  <= '0;
         row_ff     <= '0;
         count_ff   <= '0;
      end else begin
         busy_ff    <= busy_in;
         plain_ff   <= plain_in;
         trail_ff   <= trail_in;
         lastcol_ff <= lastcol_in;
         done_ff    <= done_in;
         shift_ff   <= shift_in;
         column_ff  <= column_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
      end
   end

   // the held tile becomes the previous tile of the next one
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff <= tile_ff;
         tile_ff <= req_tile_bytes;
      end
   end

endmodule

`default_nettype wire

// File: hdl/trpg_shift.sv
// Byte-wise shift and merge that forms one generated tile.
`default_nettype none

module trpg_shift
   import trpg_pkg::*;
(
   input  gen_ctl_type             gen_ctl,
   input  wire logic [TILE_W-1:0]  gen_tile,
   input  wire logic [TILE_W-1:0]  gen_prev,
   output logic      [TILE_W-1:0]  shifted
);

   logic [TILE_W-1:0] hi_src, lo_src;

   // plain: prev taken as zero; trailing: the tile itself moves into the top
   assign hi_src = gen_ctl.trail ? gen_tile : (gen_ctl.plain ? '0 : gen_prev);
   assign lo_src = gen_ctl.trail ? '0 : gen_tile;

   for (genvar b = 0; b < BYTES; b++) begin : g_byte
      assign shifted[8*b +: 8] = shift_byte(hi_src[8*b +: 8], lo_src[8*b +: 8],
                                            gen_ctl.shift);
   end

endmodule

`default_nettype wire

// File: hdl/tile_row_preshift_generator_unit.sv
// Top level of the tile row preshift generator: registers, sequencer, shifter, result register.
`default_nettype none

// Each accepted 8x8 tile produces nine words, shifts 0 to 8, or eighteen when it is
// the last tile of its row (the trailing group follows the merged group). Words leave
// one per cycle through the result register whenever rsp_stall is low; the next
// tile is accepted in the cycle the final word of the current one enters that register,
// so there are no gaps between tiles while rsp_stall stays low. Set tiles_per_row,
// row_count and dest_base only while the block is idle; after the final word of the
// last row the counters return to zero and the next tile starts a new job.

module tile_row_preshift_generator_unit
   import trpg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [TILE_W-1:0]  req_tile_bytes,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [TILE_W-1:0]  rsp_shifted_tile,
   output logic      [SHIFT_W-1:0] rsp_shift_amount,
   output logic      [INDEX_W-1:0] rsp_dest_tile,
   output logic                    rsp_last_of_item,
   output logic                    rsp_job_done,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [ADDR_W-1:0]  csr_paddr,
   input  wire logic [DATA_W-1:0]  csr_pwdata,
   output logic      [DATA_W-1:0]  csr_prdata,
   output logic                    csr_pready
);

   cfg_type            cfg;
   gen_ctl_type        gen_ctl;
   logic [TILE_W-1:0]  gen_tile, gen_prev, shifted;
   logic               out_free, emit, item_last, job_last;
   logic [INDEX_W-1:0] dest_tile;

   logic               valid_ff, valid_in;
   logic [TILE_W-1:0]  tile_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [INDEX_W-1:0] dest_ff;
   logic               last_ff, done_ff;

   trpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trpg_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_tile_bytes (req_tile_bytes),
      .req_stall      (req_stall),
      .out_free       (out_free),
      .emit           (emit),
      .gen_ctl        (gen_ctl),
      .gen_tile       (gen_tile),
      .gen_prev       (gen_prev),
      .item_last      (item_last),
      .job_last       (job_last),
      .dest_tile      (dest_tile)
   );

   trpg_shift u_shift (
      .gen_ctl  (gen_ctl),
      .gen_tile (gen_tile),
      .gen_prev (gen_prev),
      .shifted  (shifted)
   );

   // result register takes a new word when empty or when its word leaves
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tile_ff  <= shifted;
         shift_ff <= gen_ctl.shift;
         dest_ff  <= dest_tile;
         last_ff  <= item_last;
         done_ff  <= job_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_shifted_tile = tile_ff;
   assign rsp_shift_amount = shift_ff;
   assign rsp_dest_tile    = dest_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_job_done     = done_ff;

endmodule

`default_nettype wire

// File: hdl/trpg_checker.sv
// Port-level checks for the tile row preshift generator and their binding.
`default_nettype none

module trpg_checker
   import trpg_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [SHIFT_W-1:0] rsp_shift_amount,
   input wire logic [INDEX_W-1:0] rsp_dest_tile,
   input wire logic               rsp_last_of_item,
   input wire logic               rsp_job_done
);

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   // a job ends only on the final word of a tile
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_job_done) |-> rsp_last_of_item)
      else $error("job_done without last_of_item");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shift_amount <= LAST_SHIFT))
      else $error("shift amount above eight");

   // inside one tile the words follow with no gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last_of_item) |=> rsp_valid)
      else $error("gap inside one tile's words");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last_of_item) |=>
         ((rsp_shift_amount == $past(rsp_shift_amount) + 4'd1) ||
          ($past(rsp_shift_amount) == LAST_SHIFT && rsp_shift_amount == FIRST_SHIFT)))
      else $error("shift amounts out of order");

   a_dest_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last_of_item) |=> (rsp_dest_tile == $past(rsp_dest_tile) + 16'd1))
      else $error("destination index did not advance by one");

endmodule

bind tile_row_preshift_generator_unit trpg_checker u_trpg_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_shift_amount (rsp_shift_amount),
   .rsp_dest_tile    (rsp_dest_tile),
   .rsp_last_of_item (rsp_last_of_item),
   .rsp_job_done     (rsp_job_done)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the tile row preshift generator.
`timescale 1ns / 100ps

module testbench;
   import trpg_pkg::*;

   localparam int unsigned SHIFTS_PER_GROUP = 9;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam int unsigned SETTLE_CYCLES    = 24;
   localparam int unsigned HOLD_AT_WORD     = 600;
   localparam int unsigned HOLD_CYCLES      = 160;
   localparam int unsigned RANDOM_PHASES    = 7;
   localparam int unsigned TILES_PER_PHASE  = 37;

   localparam logic [ADDR_W-1:0] ADDR_TILES_PER_ROW = {REG_TILES_PER_ROW, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_ROW_COUNT     = {REG_ROW_COUNT, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_DEST_BASE     = {REG_DEST_BASE, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_SPARE         = 4'd12;

   typedef struct {
      logic [TILE_W-1:0]  tile;
      logic [SHIFT_W-1:0] shift;
      logic [INDEX_W-1:0] dest;
      logic               last;
      logic               done;
   } preshift_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [TILE_W-1:0]  req_tile_bytes = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [TILE_W-1:0]  rsp_shifted_tile;
   logic [SHIFT_W-1:0] rsp_shift_amount;
   logic [INDEX_W-1:0] rsp_dest_tile;
   logic               rsp_last_of_item;
   logic               rsp_job_done;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr = '0;
   logic [DATA_W-1:0]  csr_pwdata = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   // predictor state
   cfg_type            job_cfg = '{tiles_per_row: 8'd1, row_count: 8'd1, dest_base: '0};
   logic [TILE_W-1:0]  last_tile = '0;
   logic [7:0]         col_pos = '0;
   logic [7:0]         row_pos = '0;
   logic [INDEX_W-1:0] word_count = '0;

   logic [TILE_W-1:0]  pending_tiles[$];
   preshift_word_type  expected_words[$];

   int unsigned failures = 0;
   int unsigned tiles_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned settings_used = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned hold_left = 0;
   bit          held_long = 1'b0;
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;

   tile_row_preshift_generator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tile_bytes   (req_tile_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_shifted_tile (rsp_shifted_tile),
      .rsp_shift_amount (rsp_shift_amount),
      .rsp_dest_tile    (rsp_dest_tile),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_job_done     (rsp_job_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // expand one accepted tile into its shifted words
   function automatic void predict_preshift(input logic [TILE_W-1:0] tile);
      int unsigned       width, height, s, b, n, p, v;
      bit                last_col, last_row;
      preshift_word_type w;
      width    = (job_cfg.tiles_per_row == 8'd0) ? 1 : 32'(job_cfg.tiles_per_row);
      height   = (job_cfg.row_count == 8'd0) ? 1 : 32'(job_cfg.row_count);
      last_col = col_pos >= width - 1;
      last_row = row_pos >= height - 1;
      for (s = 0; s < SHIFTS_PER_GROUP; s++) begin
         w.tile = '0;
         for (b = 0; b < BYTES; b++) begin
            n = 32'(tile[8*b +: 8]);
            p = 32'(last_tile[8*b +: 8]);
            if (col_pos == 0) begin
               v = n >> s;
            end else begin
               v = ((n >> s) | (p << (8 - s))) & 32'hff;
            end
            w.tile[8*b +: 8] = v[7:0];
         end
         w.shift = 4'(s);
         w.dest  = job_cfg.dest_base + word_count;
         w.last  = (s == SHIFTS_PER_GROUP - 1) && !last_col;
         w.done  = 1'b0;
         expected_words.push_back(w);
         word_count++;
      end
      if (last_col) begin
         // trailing group: low s bits of each byte moved to the top
         for (s = 0; s < SHIFTS_PER_GROUP; s++) begin
            w.tile = '0;
            for (b = 0; b < BYTES; b++) begin
               n = 32'(tile[8*b +: 8]);
               v = ((n & (32'hff >> (8 - s))) << (8 - s)) & 32'hff;
               w.tile[8*b +: 8] = v[7:0];
            end
            w.shift = 4'(s);
            w.dest  = job_cfg.dest_base + word_count;
            w.last  = (s == SHIFTS_PER_GROUP - 1);
            w.done  = w.last && last_row;
            expected_words.push_back(w);
            word_count++;
         end
      end
      last_tile = tile;
      if (last_col) begin
         col_pos = '0;
         if (last_row) begin
            row_pos    = '0;
            word_count = '0;
         end else begin
            row_pos = row_pos + 8'd1;
         end
      end else begin
         col_pos = col_pos + 8'd1;
      end
   endfunction

   function automatic logic [TILE_W-1:0] random_tile();
      logic [7:0] pattern;
      pattern = 8'($urandom);
      case ($urandom_range(0, 5))
         4: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         5: return {BYTES{pattern}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // driver: offer pending tiles, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_preshift(req_tile_bytes);
            tiles_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_tiles.size() > 0) begin
               req_valid      <= 1'b1;
               req_tile_bytes <= pending_tiles.pop_front();
               if (send_idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // hold off once for a long stretch so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!held_long && results_seen >= HOLD_AT_WORD) begin
         held_long <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: check each accepted word, drive stall
   always @(posedge clock) begin
      preshift_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected word: tile %h shift %0d dest %0d last %b done %b",
                           rsp_shifted_tile, rsp_shift_amount, rsp_dest_tile,
                           rsp_last_of_item, rsp_job_done);
            end else begin
               want = expected_words.pop_front();
               if (rsp_shifted_tile !== want.tile || rsp_shift_amount !== want.shift ||
                   rsp_dest_tile !== want.dest || rsp_last_of_item !== want.last ||
                   rsp_job_done !== want.done) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("word %0d mismatch: expected tile %h shift %0d dest %0d last %b done %b",
                              results_seen, want.tile, want.shift, want.dest, want.last, want.done);
                     $display("              actual   tile %h shift %0d dest %0d last %b done %b",
                              rsp_shifted_tile, rsp_shift_amount, rsp_dest_tile,
                              rsp_last_of_item, rsp_job_done);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            rsp_stall <= 1'b1;
            recv_gap--;
         end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            recv_gap = $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         ADDR_TILES_PER_ROW: job_cfg.tiles_per_row = data[7:0];
         ADDR_ROW_COUNT:     job_cfg.row_count     = data[7:0];
         ADDR_DEST_BASE:     job_cfg.dest_base     = data[INDEX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_job(input logic [7:0] tiles, input logic [7:0] rows,
                          input logic [INDEX_W-1:0] base);
      write_reg(ADDR_TILES_PER_ROW, {24'($urandom) & 24'hffffff, tiles});
      write_reg(ADDR_ROW_COUNT, 32'(rows));
      write_reg(ADDR_DEST_BASE, 32'(base));
      settings_used++;
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) pending_tiles.push_back(random_tile());
   endtask

   // sender pauses until every expected word has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_tiles.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // single-tile jobs from reset values: extremes and a walking pattern
      pending_tiles.push_back('0);
      pending_tiles.push_back('1);
      pending_tiles.push_back(64'h8040201008040201);
      pending_tiles.push_back(64'h55aa55aa55aa55aa);
      wait_drained();

      // multi-row job with a base near the top so indices wrap
      set_job(8'd3, 8'd2, 16'hfffa);
      pending_tiles.push_back(64'hff00ff00f0f00f0f);
      pending_tiles.push_back(64'h0123456789abcdef);
      pending_tiles.push_back('1);
      send_random(3);
      wait_drained();

      // zero sizes act as one
      set_job(8'd0, 8'd0, 16'd100);
      send_random(2);
      wait_drained();

      // a write past the last register changes nothing
      write_reg(ADDR_SPARE, 32'hffffffff);
      set_job(8'd5, 8'd3, 16'd0);
      send_random(3);
      wait_drained();

      // shrink the row mid-job: current column is already beyond the end
      write_reg(ADDR_TILES_PER_ROW, 32'd2);
      send_random(2);
      wait_drained();
      write_reg(ADDR_ROW_COUNT, 32'd1);
      send_random(3);
      wait_drained();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) begin
            send_idle_on = 1'b0;
            recv_idle_on = 1'b0;
         end
         case (phase)
            0: set_job(8'd255, 8'd255, 16'hffff);
            1: set_job(8'd1, 8'd1, 16'd0);
            2: set_job(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)), 16'($urandom));
            default: set_job(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                             16'($urandom));
         endcase
         send_random(TILES_PER_PHASE);
         wait_drained();
      end

      if (expected_words.size() != 0) failures++;
      $display("Sent %0d tiles and checked %0d shifted words over %0d register settings,",
               tiles_accepted, results_seen, settings_used);
      $display("including zero and maximal sizes, index wrap, mid-job resizing and a long hold.");
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failures", failures);
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Timed out");
      $display("Verification failed");
      $finish;
   end

endmodule
